>>> rtl/morse_character_keyer_core_assert.svh
// assertion macros shared by the morse keyer rtl
// no dependencies; included by the modules that carry assertions
`ifndef MORSE_CHARACTER_KEYER_CORE_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MCK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MCK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MCK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/mck_pkg.sv
// shared types, constants and the morse code table for the keyer
// no dependencies
`default_nettype none

package mck_pkg;

    localparam int CHAR_W = 8;
    localparam int DOT_W  = 11;
    localparam int DUR_W  = 13;
    localparam int CODE_W = 7;

    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_BACKTICK = 8'h60;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

    localparam logic [DOT_W-1:0] DOT_RESET = 11'd60;

    typedef enum logic [1:0] {
        ITEM_REJECT,
        ITEM_SPACE,
        ITEM_CODE
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [CODE_W-1:0]   code;
    } q_entry_t;

    // lsb first, 1 = dash, guard bit above the last element, 0 = no code
    function automatic logic [CODE_W-1:0] code_lookup(input logic [5:0] idx);
        logic [CODE_W-1:0] c;
        unique case (idx)
            6'd0:  c = 7'h00; 6'd1:  c = 7'h35; 6'd2:  c = 7'h52; 6'd3:  c = 7'h00;
            6'd4:  c = 7'h00; 6'd5:  c = 7'h00; 6'd6:  c = 7'h00; 6'd7:  c = 7'h5E;
            6'd8:  c = 7'h2D; 6'd9:  c = 7'h6D; 6'd10: c = 7'h00; 6'd11: c = 7'h2A;
            6'd12: c = 7'h73; 6'd13: c = 7'h61; 6'd14: c = 7'h6A; 6'd15: c = 7'h29;
            6'd16: c = 7'h3F; 6'd17: c = 7'h3E; 6'd18: c = 7'h3C; 6'd19: c = 7'h38;
            6'd20: c = 7'h30; 6'd21: c = 7'h20; 6'd22: c = 7'h21; 6'd23: c = 7'h23;
            6'd24: c = 7'h27; 6'd25: c = 7'h2F; 6'd26: c = 7'h47; 6'd27: c = 7'h00;
            6'd28: c = 7'h00; 6'd29: c = 7'h31; 6'd30: c = 7'h00; 6'd31: c = 7'h4C;
            6'd32: c = 7'h56; 6'd33: c = 7'h06; 6'd34: c = 7'h11; 6'd35: c = 7'h15;
            6'd36: c = 7'h09; 6'd37: c = 7'h02; 6'd38: c = 7'h14; 6'd39: c = 7'h0B;
            6'd40: c = 7'h10; 6'd41: c = 7'h04; 6'd42: c = 7'h1E; 6'd43: c = 7'h0D;
            6'd44: c = 7'h12; 6'd45: c = 7'h07; 6'd46: c = 7'h05; 6'd47: c = 7'h0F;
            6'd48: c = 7'h16; 6'd49: c = 7'h1B; 6'd50: c = 7'h0A; 6'd51: c = 7'h08;
            6'd52: c = 7'h03; 6'd53: c = 7'h0C; 6'd54: c = 7'h18; 6'd55: c = 7'h0E;
            6'd56: c = 7'h19; 6'd57: c = 7'h1D; 6'd58: c = 7'h13; 6'd59: c = 7'h00;
            6'd60: c = 7'h00; 6'd61: c = 7'h00; 6'd62: c = 7'h68; 6'd63: c = 7'h35;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mck_front.sv
// front end: accepts characters, folds case and classifies them
// depends on mck_pkg
`default_nettype none

module mck_front (
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [mck_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                        q_full,
    output logic                             q_push,
    output mck_pkg::q_entry_t                q_entry
);

    logic [mck_pkg::CHAR_W-1:0] upper_char;
    logic [mck_pkg::CHAR_W-1:0] table_off;
    logic [mck_pkg::CODE_W-1:0] code;
    logic                       out_of_range;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign out_of_range = (char_code < mck_pkg::CHAR_SPACE) ||
                          (char_code == mck_pkg::CHAR_BACKTICK) ||
                          (char_code > mck_pkg::CHAR_LOWER_Z);

    // lower case folds onto upper case
    assign upper_char = (char_code >= mck_pkg::CHAR_LOWER_A) ?
                        (char_code - mck_pkg::CASE_OFFSET) : char_code;
    assign table_off  = upper_char - mck_pkg::CHAR_SPACE;
    assign code       = mck_pkg::code_lookup(table_off[5:0]);

    always_comb
    begin
        q_entry.code = code;
        priority if (out_of_range)
        begin
            q_entry.kind = mck_pkg::ITEM_REJECT;
        end
        else if (char_code == mck_pkg::CHAR_SPACE)
        begin
            q_entry.kind = mck_pkg::ITEM_SPACE;
        end
        else if (code == '0)
        begin
            q_entry.kind = mck_pkg::ITEM_REJECT;
        end
        else
        begin
            q_entry.kind = mck_pkg::ITEM_CODE;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mck_queue.sv
// short word queue between the front end and the segment sequencer
// depends on mck_pkg
`default_nettype none

module mck_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mck_pkg::q_entry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output mck_pkg::q_entry_t       entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mck_pkg::q_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mck_back.sv
// back end: steps through a code word and emits keyed segments
// depends on mck_pkg and morse_character_keyer_core_assert.svh
`default_nettype none
`include "morse_character_keyer_core_assert.svh"

module mck_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [mck_pkg::DOT_W-1:0]   dot_length_ms,
    input  wire logic                        q_valid,
    input  wire mck_pkg::q_entry_t           q_entry,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             key_on,
    output logic [mck_pkg::DUR_W-1:0]        duration_ms,
    output logic                             last,
    output logic                             rejected
);

    typedef enum logic {
        S_IDLE,
        S_MARK
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [mck_pkg::CODE_W-1:0]  code_reg;
    logic [mck_pkg::CODE_W-1:0]  code_next;
    logic                        gap_reg;
    logic                        gap_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_key_on_reg;
    logic                        out_key_on_next;
    logic [mck_pkg::DUR_W-1:0]   out_dur_reg;
    logic [mck_pkg::DUR_W-1:0]   out_dur_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    logic                        out_rejected_reg;
    logic                        out_rejected_next;

    logic                        load;
    logic [mck_pkg::DUR_W-1:0]   dot1;
    logic [mck_pkg::DUR_W-1:0]   dot2;
    logic [mck_pkg::DUR_W-1:0]   dot3;
    logic [mck_pkg::DUR_W-1:0]   dot4;

    assign dot1 = {{(mck_pkg::DUR_W - mck_pkg::DOT_W){1'b0}}, dot_length_ms};
    assign dot2 = dot1 << 1;
    assign dot4 = dot1 << 2;
    assign dot3 = dot2 + dot1;

    assign load = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        code_next         = code_reg;
        gap_next          = gap_reg;
        out_valid_next    = out_valid_reg;
        out_key_on_next   = out_key_on_reg;
        out_dur_next      = out_dur_reg;
        out_last_next     = out_last_reg;
        out_rejected_next = out_rejected_reg;
        q_pop             = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b0;
                    if (q_valid)
                    begin
                        q_pop = 1'b1;
                        unique case (q_entry.kind)
                            mck_pkg::ITEM_SPACE:
                            begin
                                out_valid_next    = 1'b1;
                                out_key_on_next   = 1'b0;
                                out_dur_next      = dot4;
                                out_last_next     = 1'b1;
                                out_rejected_next = 1'b0;
                            end
                            mck_pkg::ITEM_CODE:
                            begin
                                state_next = S_MARK;
                                code_next  = q_entry.code;
                                gap_next   = 1'b0;
                            end
                            default:
                            begin
                                out_valid_next    = 1'b1;
                                out_key_on_next   = 1'b0;
                                out_dur_next      = '0;
                                out_last_next     = 1'b1;
                                out_rejected_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_MARK:
            begin
                if (load)
                begin
                    out_valid_next    = 1'b1;
                    out_rejected_next = 1'b0;
                    if (gap_reg)
                    begin
                        out_key_on_next = 1'b0;
                        out_dur_next    = dot1;
                        out_last_next   = 1'b0;
                        code_next       = code_reg >> 1;
                        gap_next        = 1'b0;
                    end
                    else if (code_reg[mck_pkg::CODE_W-1:1] != '0)
                    begin
                        // dash on a one, dot on a zero
                        out_key_on_next = 1'b1;
                        out_dur_next    = code_reg[0] ? dot3 : dot1;
                        out_last_next   = 1'b0;
                        gap_next        = 1'b1;
                    end
                    else
                    begin
                        // guard bit reached: letter gap closes the character
                        out_key_on_next = 1'b0;
                        out_dur_next    = dot2;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            code_reg         <= '0;
            gap_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_key_on_reg   <= 1'b0;
            out_dur_reg      <= '0;
            out_last_reg     <= 1'b0;
            out_rejected_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            code_reg         <= code_next;
            gap_reg          <= gap_next;
            out_valid_reg    <= out_valid_next;
            out_key_on_reg   <= out_key_on_next;
            out_dur_reg      <= out_dur_next;
            out_last_reg     <= out_last_next;
            out_rejected_reg <= out_rejected_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign key_on      = out_key_on_reg;
    assign duration_ms = out_dur_reg;
    assign last        = out_last_reg;
    assign rejected    = out_rejected_reg;

    `MCK_ASSERT_IMP(a_reject_form, clk, rst_n, out_valid_reg && out_rejected_reg,
        out_last_reg && !out_key_on_reg && (out_dur_reg == '0), "bad rejected word")
    `MCK_ASSERT_IMP(a_mark_not_last, clk, rst_n, out_valid_reg && out_key_on_reg,
        !out_last_reg && !out_rejected_reg, "key-on word marked last or rejected")
    `MCK_ASSERT_IMP(a_element_then_gap, clk, rst_n,
        (state_reg == S_MARK) && !gap_reg && out_valid_reg, !out_key_on_reg,
        "element not followed by gap")
    `MCK_ASSERT_NXT(a_pop_progress, clk, rst_n, q_pop,
        out_valid_reg || (state_reg == S_MARK), "popped word produced nothing")

endmodule

`default_nettype wire

>>> rtl/morse_character_keyer_core.sv
// morse keyer top level: apb register, front end, queue and segment sequencer
// depends on mck_pkg, mck_front, mck_queue, mck_back
//
// usage: one ascii character enters per word on in_valid/in_stall/char_code.
// each character yields keyed segments on out_valid/out_stall with key_on,
// duration_ms, last and rejected; last marks the final segment of a character.
// a letter of n elements gives 2n+1 segments, a space or an unsupported
// character gives exactly one.
// first segments pass the queue and the segment register; a letter's also
// waits for its code word to load. throughput: the sequencer emits one
// segment per cycle unless out_stall holds it, but a letter's load emits
// none, and it takes a character only after the last segment of the one
// before. the input queue absorbs QUEUE_DEPTH characters meanwhile.
// dot_length_ms sits at apb address 0; write it only while the block is idle.
// reset: queue and sequencer empty, no segment valid, dot length 60 ms.
// receiver stall: the segment register holds; the sequencer waits, and
// in_stall rises once the queue fills.
`default_nettype none

module morse_character_keyer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [mck_pkg::CHAR_W-1:0]  char_code,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             key_on,
    output logic [mck_pkg::DUR_W-1:0]        duration_ms,
    output logic                             last,
    output logic                             rejected
);

    localparam logic REG_DOT_LENGTH = 1'b0;

    logic [mck_pkg::DOT_W-1:0] dot_length_reg;
    logic                      cfg_write;
    logic                      q_full;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_valid;
    mck_pkg::q_entry_t         push_entry;
    mck_pkg::q_entry_t         head_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DOT_LENGTH);
    assign prdata    = (paddr[2] == REG_DOT_LENGTH) ?
                       {{(32 - mck_pkg::DOT_W){1'b0}}, dot_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_length_reg <= mck_pkg::DOT_RESET;
        end
        else if (cfg_write)
        begin
            dot_length_reg <= pwdata[mck_pkg::DOT_W-1:0];
        end
    end

    mck_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    mck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .entry      (head_entry)
    );

    mck_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .dot_length_ms (dot_length_reg),
        .q_valid       (q_valid),
        .q_entry       (head_entry),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .key_on        (key_on),
        .duration_ms   (duration_ms),
        .last          (last),
        .rejected      (rejected)
    );

endmodule

`default_nettype wire

>>> tb/morse_segment_checker.sv
// checker for the morse keyer: tracks the dot length register from the apb bus,
// predicts the segments of every accepted character and compares them in order
// depends on mck_pkg for the character constants
`timescale 1ns / 1ps

module morse_segment_checker #(
    parameter logic [2:0] DOT_ADDR = 3'd0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    input  wire logic                        pready,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [mck_pkg::CHAR_W-1:0]  char_code,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic                        key_on,
    input  wire logic [mck_pkg::DUR_W-1:0]   duration_ms,
    input  wire logic                        last,
    input  wire logic                        rejected,
    output int                               errors,
    output int                               pending
);

    typedef struct packed {
        logic                      key_on;
        logic [mck_pkg::DUR_W-1:0] duration_ms;
        logic                      last;
        logic                      rejected;
    } segment_t;

    segment_t                  segments_due [$];
    logic [mck_pkg::DOT_W-1:0] dot_ms;

    initial errors = 0;

    // lsb first, 1 = dash, guard bit above the last element, 0 = not sendable
    function automatic logic [mck_pkg::CODE_W-1:0] morse_pattern(
        input logic [mck_pkg::CHAR_W-1:0] ch);
        case (ch)
            "!": return 7'h35;  "\"": return 7'h52; "'": return 7'h5E;
            "(": return 7'h2D;  ")": return 7'h6D;  "+": return 7'h2A;
            ",": return 7'h73;  "-": return 7'h61;  ".": return 7'h6A;
            "/": return 7'h29;  "0": return 7'h3F;  "1": return 7'h3E;
            "2": return 7'h3C;  "3": return 7'h38;  "4": return 7'h30;
            "5": return 7'h20;  "6": return 7'h21;  "7": return 7'h23;
            "8": return 7'h27;  "9": return 7'h2F;  ":": return 7'h47;
            "=": return 7'h31;  "?": return 7'h4C;  "@": return 7'h56;
            "A": return 7'h06;  "B": return 7'h11;  "C": return 7'h15;
            "D": return 7'h09;  "E": return 7'h02;  "F": return 7'h14;
            "G": return 7'h0B;  "H": return 7'h10;  "I": return 7'h04;
            "J": return 7'h1E;  "K": return 7'h0D;  "L": return 7'h12;
            "M": return 7'h07;  "N": return 7'h05;  "O": return 7'h0F;
            "P": return 7'h16;  "Q": return 7'h1B;  "R": return 7'h0A;
            "S": return 7'h08;  "T": return 7'h03;  "U": return 7'h0C;
            "V": return 7'h18;  "W": return 7'h0E;  "X": return 7'h19;
            "Y": return 7'h1D;  "Z": return 7'h13;  "^": return 7'h68;
            "_": return 7'h35;
            default: return 7'h00;
        endcase
    endfunction

    task automatic predict_segments(input logic [mck_pkg::CHAR_W-1:0] ch);
        logic [mck_pkg::DUR_W-1:0]  dot;
        logic [mck_pkg::CHAR_W-1:0] upper;
        logic [mck_pkg::CODE_W-1:0] pat;
        dot   = mck_pkg::DUR_W'(dot_ms);
        upper = ch;
        if (ch < mck_pkg::CHAR_SPACE || ch == mck_pkg::CHAR_BACKTICK ||
            ch > mck_pkg::CHAR_LOWER_Z)
        begin
            segments_due.push_back('{1'b0, '0, 1'b1, 1'b1});
            return;
        end
        if (ch == mck_pkg::CHAR_SPACE)
        begin
            segments_due.push_back('{1'b0, mck_pkg::DUR_W'(4 * dot), 1'b1, 1'b0});
            return;
        end
        if (ch >= mck_pkg::CHAR_LOWER_A)
            upper = ch - mck_pkg::CASE_OFFSET;
        pat = morse_pattern(upper);
        if (pat == '0)
        begin
            segments_due.push_back('{1'b0, '0, 1'b1, 1'b1});
            return;
        end
        while (pat > 1)
        begin
            segments_due.push_back('{1'b1, pat[0] ? mck_pkg::DUR_W'(3 * dot) : dot,
                                     1'b0, 1'b0});
            segments_due.push_back('{1'b0, dot, 1'b0, 1'b0});
            pat = pat >> 1;
        end
        segments_due.push_back('{1'b0, mck_pkg::DUR_W'(2 * dot), 1'b1, 1'b0});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        if (!rst_n)
        begin
            dot_ms = mck_pkg::DOT_RESET;
            segments_due.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == DOT_ADDR)
                dot_ms = pwdata[mck_pkg::DOT_W-1:0];
            if (out_valid && !out_stall)
            begin
                if (segments_due.size() == 0)
                begin
                    $error("unexpected segment: key_on %0d duration_ms %0d last %0d rejected %0d",
                           key_on, duration_ms, last, rejected);
                    errors++;
                end
                else
                begin
                    want = segments_due.pop_front();
                    if (key_on !== want.key_on)
                    begin
                        $error("key_on: expected %0d, got %0d", want.key_on, key_on);
                        errors++;
                    end
                    if (duration_ms !== want.duration_ms)
                    begin
                        $error("duration_ms: expected %0d, got %0d",
                               want.duration_ms, duration_ms);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors++;
                    end
                    if (rejected !== want.rejected)
                    begin
                        $error("rejected: expected %0d, got %0d", want.rejected, rejected);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_segments(char_code);
            pending <= segments_due.size();
        end
    end

endmodule

>>> tb/tb.sv
// top of the morse keyer testbench: clock, reset, apb writes, character stimulus
// and receiver stalls; depends on mck_pkg, morse_character_keyer_core and
// morse_segment_checker, which predicts and compares the segments
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] DOT_ADDR    = 3'd0;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         RAND_WORDS  = 140;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [2:0]                   paddr     = '0;
    logic [31:0]                  pwdata    = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic [mck_pkg::CHAR_W-1:0]   char_code = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         key_on;
    logic [mck_pkg::DUR_W-1:0]    duration_ms;
    logic                         last;
    logic                         rejected;

    int                           errors;
    int                           pending;
    int                           send_idle_pct  = 0;
    int                           stall_pct      = 0;
    int                           cycle_count    = 0;
    logic [mck_pkg::CHAR_W-1:0]   corner_chars [$];
    logic [mck_pkg::CHAR_W-1:0]   dot_probe_chars [$];

    morse_character_keyer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_on     (key_on),
        .duration_ms(duration_ms),
        .last       (last),
        .rejected   (rejected)
    );

    morse_segment_checker #(.DOT_ADDR(DOT_ADDR)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_on     (key_on),
        .duration_ms(duration_ms),
        .last       (last),
        .rejected   (rejected),
        .errors     (errors),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(input logic [mck_pkg::CHAR_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_segments();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_dot_length(input logic [mck_pkg::DOT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DOT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_words(input int count);
        logic [mck_pkg::CHAR_W-1:0] ch;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 75)
                ch = mck_pkg::CHAR_W'($urandom_range(mck_pkg::CHAR_LOWER_Z,
                                                     mck_pkg::CHAR_SPACE));
            else
                ch = mck_pkg::CHAR_W'($urandom_range(255));
            send_word(ch);
            if (i == count / 2)
                drain_segments();
        end
        drain_segments();
    endtask

    initial
    begin
        // out of range, space, table holes, both cases, longest codes
        corner_chars = '{8'h00, 8'h1F, 8'h20, 8'h21, 8'h23, 8'h2C, 8'h30, 8'h3F,
                         8'h40, 8'h41, 8'h5A, 8'h5B, 8'h5E, 8'h5F, 8'h60, 8'h61,
                         8'h7A, 8'h7B, 8'h80, 8'hFF};
        dot_probe_chars = '{8'h30, 8'h20, 8'h65};

        send_idle_pct <= 20;
        stall_pct     <= 72;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_chars[i])
            send_word(corner_chars[i]);
        drain_segments();

        write_dot_length('0);
        foreach (dot_probe_chars[i])
            send_word(dot_probe_chars[i]);
        drain_segments();

        write_dot_length({mck_pkg::DOT_W{1'b1}});
        foreach (dot_probe_chars[i])
            send_word(dot_probe_chars[i]);
        drain_segments();

        write_dot_length(mck_pkg::DOT_W'(1));
        send_random_words(RAND_WORDS);

        send_idle_pct <= 72;
        stall_pct     <= 20;
        write_dot_length(mck_pkg::DOT_W'(1200));
        send_random_words(RAND_WORDS);

        send_idle_pct <= 0;
        stall_pct     <= 0;
        write_dot_length(mck_pkg::DOT_W'($urandom_range(2047)));
        send_random_words(RAND_WORDS);

        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
